// ===== src/sn2d_pkg.sv =====
// Package for the 2-D simplex noise block: fixed-point constants,
// permutation table and gradient helper. No dependencies.
package sn2d_pkg;

	localparam int FracBits = 16;
	localparam int PermEntries = 256;
	localparam int UpShift = 24 - FracBits;

	localparam logic signed [24:0] F2Q24 = 25'sd6140887;
	localparam logic signed [31:0] G2Q32 = 32'sd907633384;
	localparam logic signed [27:0] G2Q24 = 28'sd3545443;
	localparam logic signed [27:0] OneQ24 = 28'sd16777216;
	localparam logic signed [27:0] TwoQ24 = 28'sd33554432;
	localparam logic signed [51:0] HalfQ48 = 52'sd140737488355328;
	localparam logic signed [23:0] AmpQ16 = 24'sd2964236;
	localparam logic [7:0] GradMask = 8'h3F;
	localparam logic [15:0] FreqReset = 16'd256;

	typedef logic signed [27:0] off_t;   // corner offset, Q.24, within +-2

	localparam logic [7:0] PERM [PermEntries] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
		8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
		8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
		8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
		8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
		8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
		8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
		8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
		8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
		8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
		8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
		8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
		8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
		8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
		8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
		8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
		8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
		8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
		8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	// Clamp a Q.24 offset to [-2, +2]
	function automatic off_t clamp2(input logic signed [40:0] v);
		if (v > 41'(TwoQ24)) return TwoQ24;
		if (v < -41'(TwoQ24)) return -TwoQ24;
		return v[27:0];
	endfunction

	// Gradient dot product selected by the hashed code
	function automatic logic signed [30:0] grad(input logic [7:0] h, input off_t dx,
			input off_t dy);
		logic [7:0] hm;
		logic signed [30:0] u;
		logic signed [30:0] v;
		hm = h & GradMask;
		u = (hm < 8'd4) ? 31'(dx) : 31'(dy);
		v = (hm < 8'd4) ? 31'(dy) : 31'(dx);
		return (hm[0] ? -u : u) + (hm[1] ? -(v <<< 1) : (v <<< 1));
	endfunction

endpackage

// ===== src/simplex_noise_2d_top.sv =====
// Top level of the 2-D simplex noise generator: frequency register,
// skew pipeline, three corner units and output scaling. Depends on sn2d_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  in       | in_valid/in_ready  | x_coord, y_coord
//  out      | out_valid/out_ready| noise_value
//  cfg      | cfg_valid/cfg_ready| cfg_data (frequency, Q8.8)
//
// One item a cycle unless the output is held.
// Reset sets frequency to 1.0 and empties the pipeline.
// The pipeline advances as a whole; a held output stalls every stage and
// the input with it, so nothing is lost or repeated.
module simplex_noise_2d_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import sn2d_pkg::*;

	localparam int Stages = 11;

	logic [15:0] freq_q;
	logic [Stages-1:0] vld;
	logic [Stages-1:0] en;
	logic adv;

	// Stall the whole pipe when the output is held
	assign adv = !out_valid || out_ready;
	assign en = {Stages{adv}};
	assign in_ready = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vld[Stages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FreqReset;
			vld <= '0;
		end else begin
			if (cfg_valid) freq_q <= cfg_data;
			if (adv) vld <= {vld[Stages-2:0], in_valid};
		end
	end

	// Stage 1: scale by frequency
	logic signed [48:0] xm, ym;
	logic signed [31:0] x_s1, y_s1;
	assign xm = 49'(x_coord) * $signed({33'd0, freq_q});
	assign ym = 49'(y_coord) * $signed({33'd0, freq_q});
	always_ff @(posedge clk) if (en[0]) begin
		x_s1 <= xm[39:8];
		y_s1 <= ym[39:8];
	end

	// Stage 2: skew factor
	logic signed [32:0] sxy;
	logic signed [57:0] sk;
	logic signed [31:0] x_s2, y_s2;
	logic signed [33:0] s_s2;
	assign sxy = 33'(x_s1) + 33'(y_s1);
	assign sk = 58'(sxy) * 58'(F2Q24);
	always_ff @(posedge clk) if (en[1]) begin
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		s_s2 <= sk[57:24];
	end

	// Stage 3: cell indices
	logic signed [34:0] xs, ys;
	logic signed [18:0] ci_s3, cj_s3;
	logic signed [31:0] x_s3, y_s3;
	assign xs = 35'(x_s2) + 35'(s_s2);
	assign ys = 35'(y_s2) + 35'(s_s2);
	always_ff @(posedge clk) if (en[2]) begin
		ci_s3 <= xs[34:FracBits];
		cj_s3 <= ys[34:FracBits];
		x_s3 <= x_s2;
		y_s3 <= y_s2;
	end

	// Stage 4: unskew
	logic signed [51:0] tp;
	logic signed [35:0] t_s4;
	logic signed [18:0] ci_s4, cj_s4;
	logic signed [31:0] x_s4, y_s4;
	assign tp = 52'(20'(ci_s3) + 20'(cj_s3)) * 52'(G2Q32);
	always_ff @(posedge clk) if (en[3]) begin
		t_s4 <= tp[51:32-FracBits];
		ci_s4 <= ci_s3;
		cj_s4 <= cj_s3;
		x_s4 <= x_s3;
		y_s4 <= y_s3;
	end

	// Stage 5: corner offsets, triangle and hash
	logic signed [40:0] x0, y0;
	off_t d0x, d0y;
	logic i1;
	logic [7:0] ui, uj, pj0, pj1, pj2;
	off_t d0x_s5, d0y_s5, d1x_s5, d1y_s5, d2x_s5, d2y_s5;
	logic [7:0] h0_s5, h1_s5, h2_s5;
	assign x0 = 41'(x_s4) - (41'(ci_s4) <<< FracBits) + 41'(t_s4);
	assign y0 = 41'(y_s4) - (41'(cj_s4) <<< FracBits) + 41'(t_s4);
	assign d0x = clamp2(x0 <<< UpShift);
	assign d0y = clamp2(y0 <<< UpShift);
	assign i1 = d0x > d0y;
	assign ui = ci_s4[7:0];
	assign uj = cj_s4[7:0];
	assign pj0 = PERM[uj];
	assign pj1 = PERM[uj + {7'd0, !i1}];
	assign pj2 = PERM[uj + 8'd1];
	always_ff @(posedge clk) if (en[4]) begin
		d0x_s5 <= d0x;
		d0y_s5 <= d0y;
		d1x_s5 <= d0x - (i1 ? OneQ24 : 28'sd0) + G2Q24;
		d1y_s5 <= d0y - (i1 ? 28'sd0 : OneQ24) + G2Q24;
		d2x_s5 <= d0x - OneQ24 + (G2Q24 <<< 1);
		d2y_s5 <= d0y - OneQ24 + (G2Q24 <<< 1);
		h0_s5 <= PERM[ui + pj0];
		h1_s5 <= PERM[ui + {7'd0, i1} + pj1];
		h2_s5 <= PERM[ui + 8'd1 + pj2];
	end

	// Stages 6-10: corner terms
	logic signed [31:0] c0, c1, c2;
	sn2d_corner u_c0 (.clk, .en(en[9:5]), .dx(d0x_s5), .dy(d0y_s5),
		.hash(h0_s5), .term(c0));
	sn2d_corner u_c1 (.clk, .en(en[9:5]), .dx(d1x_s5), .dy(d1y_s5),
		.hash(h1_s5), .term(c1));
	sn2d_corner u_c2 (.clk, .en(en[9:5]), .dx(d2x_s5), .dy(d2y_s5),
		.hash(h2_s5), .term(c2));

	// Stage 11: amplitude, round and saturate
	logic signed [33:0] sum;
	logic signed [58:0] sc;
	logic signed [33:0] r;
	assign sum = 34'(c0) + 34'(c1) + 34'(c2);
	assign sc = 59'(sum) * 59'(AmpQ16) + 59'(1 <<< 24);
	assign r = sc[58:25];
	always_ff @(posedge clk) if (en[10]) begin
		if (r > 34'sd32767) noise_value <= 16'sd32767;
		else if (r < -34'sd32768) noise_value <= -16'sd32768;
		else noise_value <= r[15:0];
	end

	// Held output keeps its value
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("output changed while stalled");
	// An advance captures the input valid into the first valid stage
	ap_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld[0] == $past(in_valid))
		else $error("valid not captured");

endmodule

// ===== src/sn2d_corner.sv =====
// Pipelined attenuation and gradient term of one simplex corner.
// Depends on sn2d_pkg.
module sn2d_corner (
	input  logic                  clk,
	input  logic [4:0]            en,       // per-stage advance
	input  sn2d_pkg::off_t        dx,
	input  sn2d_pkg::off_t        dy,
	input  logic [7:0]            hash,
	output logic signed [31:0]    term
);
	import sn2d_pkg::*;

	logic signed [55:0] dxx_s1, dyy_s1;
	logic signed [30:0] g_s1, g_s2, g_s3, g_s4;
	logic signed [56:0] a_full;
	logic               neg_s2, neg_s3, neg_s4;
	logic signed [31:0] a_s2;
	logic signed [63:0] a2_full, a4_full;
	logic signed [31:0] a2_s3, a4_s4;
	logic signed [62:0] t_full;

	assign a_full = 57'(HalfQ48) - 57'(dxx_s1) - 57'(dyy_s1);
	assign a2_full = 64'(a_s2) * 64'(a_s2);
	assign a4_full = 64'(a2_s3) * 64'(a2_s3);
	assign t_full = 63'(a4_s4) * 63'(g_s4);

	// Square offsets, pick gradient, form the attenuated term
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dxx_s1 <= 56'(dx) * 56'(dx);
			dyy_s1 <= 56'(dy) * 56'(dy);
			g_s1 <= grad(hash, dx, dy);
		end
		if (en[1]) begin
			neg_s2 <= a_full[56];
			a_s2 <= a_full[55:24];
			g_s2 <= g_s1;
		end
		if (en[2]) begin
			a2_s3 <= a2_full[55:24];
			neg_s3 <= neg_s2;
			g_s3 <= g_s2;
		end
		if (en[3]) begin
			a4_s4 <= a4_full[55:24];
			neg_s4 <= neg_s3;
			g_s4 <= g_s3;
		end
		if (en[4]) begin
			term <= neg_s4 ? 32'sd0 : t_full[55:24];
		end
	end

endmodule

// ===== tb/tb_simplex_noise_2d_top.sv =====
// Self-checking testbench for simplex_noise_2d_top: random and directed coordinates
// at several frequency settings, predicted in place and compared per transaction.
// Depends on sn2d_pkg and the simplex_noise_2d_top RTL.
module tb_simplex_noise_2d_top;
	import sn2d_pkg::*;

	localparam int Latency = 11;
	localparam longint CycleLimit = 400000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} coord_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] noise_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	coord_t pending_coords[$];
	logic signed [15:0] expected_noise[$];
	logic [15:0] freq_model;
	int mismatches;
	int samples_checked;
	int gap_left;
	int stall_left;
	int freq_settings;
	longint cycle_count;
	bit sender_hold;

	simplex_noise_2d_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .x_coord(x_coord), .y_coord(y_coord),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(v / 2^sh) for signed values
	function automatic longint floor_shift(input longint v, input int sh);
		return v >>> sh;
	endfunction

	function automatic longint clamp_two(input longint v);
		if (v > 2 * longint'(OneQ24)) return 2 * longint'(OneQ24);
		if (v < -2 * longint'(OneQ24)) return -2 * longint'(OneQ24);
		return v;
	endfunction

	function automatic longint corner_term(input longint dx_in, input longint dy_in,
			input logic [7:0] hash);
		longint dx, dy, atten, u, v, g;
		logic [7:0] h;
		dx = clamp_two(dx_in);
		dy = clamp_two(dy_in);
		atten = longint'(HalfQ48) - dx * dx - dy * dy;
		if (atten < 0) return 0;
		atten = floor_shift(atten, 24);
		atten = floor_shift(atten * atten, 24);
		atten = floor_shift(atten * atten, 24);
		h = hash & 8'h3F;
		u = (h < 8'd4) ? dx : dy;
		v = (h < 8'd4) ? dy : dx;
		g = (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
		return floor_shift(atten * g, 24);
	endfunction

	function automatic logic [7:0] perm_lookup(input longint k);
		return PERM[k & (PermEntries - 1)];
	endfunction

	// Predict the noise sample for one coordinate pair at the current frequency
	function automatic logic signed [15:0] predict_noise(input coord_t c);
		longint x, y, s, ci, cj, t, x0, y0, dx0, dy0, i1, j1, sum, r;
		logic signed [31:0] wrapped;
		x = longint'(c.x);
		y = longint'(c.y);
		wrapped = 32'(floor_shift(x * longint'(freq_model), 8));
		x = longint'(wrapped);
		wrapped = 32'(floor_shift(y * longint'(freq_model), 8));
		y = longint'(wrapped);
		s = floor_shift((x + y) * longint'(F2Q24), 24);
		ci = floor_shift(x + s, FracBits);
		cj = floor_shift(y + s, FracBits);
		t = floor_shift((ci + cj) * longint'(G2Q32), 32 - FracBits);
		x0 = x - ci * (longint'(1) << FracBits) + t;
		y0 = y - cj * (longint'(1) << FracBits) + t;
		dx0 = clamp_two(x0 * (longint'(1) << UpShift));
		dy0 = clamp_two(y0 * (longint'(1) << UpShift));
		if (dx0 > dy0) begin
			i1 = 1;
			j1 = 0;
		end else begin
			i1 = 0;
			j1 = 1;
		end
		sum = corner_term(dx0, dy0, perm_lookup(ci + perm_lookup(cj)));
		sum += corner_term(dx0 - i1 * longint'(OneQ24) + longint'(G2Q24),
			dy0 - j1 * longint'(OneQ24) + longint'(G2Q24),
			perm_lookup(ci + i1 + perm_lookup(cj + j1)));
		sum += corner_term(dx0 - longint'(OneQ24) + 2 * longint'(G2Q24),
			dy0 - longint'(OneQ24) + 2 * longint'(G2Q24),
			perm_lookup(ci + 1 + perm_lookup(cj + 1)));
		r = floor_shift(sum * longint'(AmpQ16) + (longint'(1) << 24), 25);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return 32'($urandom_range(0, 255) << 16) | 32'($urandom_range(0, 3) << 14);
		endcase
	endfunction

	// Driver: present queued coordinates, hold each until its transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			x_coord <= '0;
			y_coord <= '0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid && in_ready) begin
				expected_noise.push_back(predict_noise('{x_coord, y_coord}));
				void'(pending_coords.pop_front());
			end
			if (in_valid && in_ready && pending_coords.size() != 0 && $urandom_range(0, 99) < 40) begin
				gap_left <= pick_gap();
				in_valid <= 1'b0;
			end else if (gap_left != 0 && !(in_valid && in_ready && pending_coords.size() != 0)) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_coords.size() != 0 && !sender_hold) begin
				in_valid <= 1'b1;
				x_coord <= pending_coords[0].x;
				y_coord <= pending_coords[0].y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_noise.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected noise_value %0d with nothing pending", noise_value);
				end else begin
					if (noise_value !== expected_noise[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("noise_value mismatch: expected %0d, got %0d",
								expected_noise[0], noise_value);
					end
					void'(expected_noise.pop_front());
					samples_checked++;
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall_left <= pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_coords.size() != 0 || in_valid || expected_noise.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frequency(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		freq_model = value;
		freq_settings++;
	endtask

	task automatic queue_coord(input logic [31:0] x, input logic [31:0] y);
		pending_coords.push_back('{x, y});
	endtask

	initial begin
		logic [15:0] freq_choice [6];
		freq_choice = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd77, 16'd256};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		freq_model = FreqReset;
		mismatches = 0;
		samples_checked = 0;
		freq_settings = 0;
		cycle_count = 0;
		sender_hold = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, tied triangle, negative cells, overflow wrap
		queue_coord(32'h0000_0000, 32'h0000_0000);
		queue_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_coord(32'h8000_0000, 32'h8000_0000);
		queue_coord(32'h7FFF_FFFF, 32'h8000_0000);
		queue_coord(32'h8000_0000, 32'h7FFF_FFFF);
		queue_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_coord(32'h0001_8000, 32'h0001_8000);
		queue_coord(32'h0000_4000, 32'h0000_4000);
		queue_coord(32'hFFFE_8000, 32'h0002_2000);
		queue_coord(32'h0100_0000, 32'hFF00_0000);
		queue_coord(32'h5555_5555, 32'hAAAA_AAAA);
		queue_coord(32'h0000_8000, 32'h0000_3000);
		wait_drained();

		write_frequency(16'hFFFF);
		queue_coord(32'h7FFF_FFFF, 32'h0001_0000);
		queue_coord(32'h0123_4567, 32'hFEDC_BA98);
		queue_coord(32'h8000_0000, 32'hFFFF_0000);
		wait_drained();
		repeat (Latency + 2) @(posedge clk);

		// Random phases over several frequencies, extremes among them
		for (int phase = 0; phase < 6; phase++) begin
			write_frequency(phase < 5 && phase != 4 ? freq_choice[phase] : 16'($urandom));
			for (int n = 0; n < 280; n++) begin
				queue_coord(random_coord(), random_coord());
				if (n == 140) begin
					// Wait until every result is back, then hold the sender idle before resuming
					while (pending_coords.size() != 0 || in_valid || expected_noise.size() != 0)
						@(posedge clk);
					sender_hold = 1'b1;
					wait_drained();
					repeat ($urandom_range(1, 8)) @(posedge clk);
					sender_hold = 1'b0;
				end
			end
			wait_drained();
			repeat (Latency + 2) @(posedge clk);
		end
		write_frequency(freq_choice[5]);

		repeat (Latency + 5) @(posedge clk);
		$display("Covered %0d samples over %0d frequency settings with random stalls.",
			samples_checked, freq_settings);
		if (mismatches == 0 && expected_noise.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== simplex_noise_2d_top.f =====
src/sn2d_pkg.sv
src/sn2d_corner.sv
src/simplex_noise_2d_top.sv
tb/tb_simplex_noise_2d_top.sv
